// ===== hw/rtl/ctl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_pkg: shared types for the connection table
// key layout and the per-word control flags that travel along the cell chain
// ----------------------------------------------------------------------------
package ctl_pkg;

    localparam int unsigned PROTO_W = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned INDEX_W = 8;

    // five-tuple key
    typedef struct packed {
        logic [PROTO_W-1:0] protocol;
        logic [ADDR_W-1:0]  source_address;
        logic [ADDR_W-1:0]  destination_address;
        logic [PORT_W-1:0]  source_port;
        logic [PORT_W-1:0]  destination_port;
    } flow_key_t;

    // flags riding with a word through the chain
    typedef struct packed {
        logic valid;
        logic hit;
        logic ins;
    } flow_ctl_t;

endpackage

// ===== hw/rtl/ctl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_cell: one table entry of the connection table
// holds one stored key, compares the passing word and hands it to the next cell
// ----------------------------------------------------------------------------
module ctl_cell
    import ctl_pkg::*;
#(
    parameter int unsigned IDX_W    = 8,
    parameter int unsigned CELL_IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  flow_ctl_t        in_ctl,
    input  flow_key_t        in_key,
    input  logic [IDX_W-1:0] in_idx,
    output flow_ctl_t        out_ctl,
    output flow_key_t        out_key,
    output logic [IDX_W-1:0] out_idx,
    output logic             occupied
);

    logic             used_reg;
    logic             used_next;
    flow_key_t        stored_reg;
    flow_ctl_t        ctl_reg;
    flow_ctl_t        ctl_next;
    flow_key_t        key_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             match;
    logic             take;

    // first free cell reached with no hit so far: the word lands here
    assign match = in_ctl.valid && used_reg && (stored_reg == in_key);
    assign take  = in_ctl.valid && !used_reg && !in_ctl.hit && !in_ctl.ins;

    always_comb
    begin
        ctl_next  = in_ctl;
        idx_next  = in_idx;
        used_next = used_reg;
        if (match)
        begin
            // later match wins
            ctl_next.hit = 1'b1;
            idx_next     = IDX_W'(CELL_IDX);
        end
        if (take)
        begin
            ctl_next.ins = 1'b1;
            idx_next     = IDX_W'(CELL_IDX);
            used_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            ctl_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            ctl_reg  <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= in_key;
        idx_reg <= idx_next;
        if (take)
        begin
            stored_reg <= in_key;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_key  = key_reg;
    assign out_idx  = idx_reg;
    assign occupied = used_reg;

endmodule

// ===== hw/rtl/connection_table_lookup_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_table_lookup_insert: five-tuple flow table, lookup with insert
// a chain of table cells; each key word walks the chain one cell per cycle
// ----------------------------------------------------------------------------
// each word passes the register of every cell in turn; done comes off the last one
// throughput: one word per cycle, busy stays low; one cell per chain stage;
// results leave in acceptance order
// reset: asynchronous, empties the table and drops every word in flight
// the receiver cannot stall: done is high for exactly one cycle per word
// ----------------------------------------------------------------------------
module connection_table_lookup_insert
    import ctl_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    // command side
    input  logic                start,
    output logic                busy,
    input  logic [PROTO_W-1:0]  protocol,
    input  logic [ADDR_W-1:0]   source_address,
    input  logic [ADDR_W-1:0]   destination_address,
    input  logic [PORT_W-1:0]   source_port,
    input  logic [PORT_W-1:0]   destination_port,
    // result side
    output logic                done,
    output logic                found,
    output logic                inserted,
    output logic                table_full,
    output logic [INDEX_W-1:0]  entry_index
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // chain taps: tap 0 is the input word, tap k is the output of cell k-1
    flow_ctl_t        ctl_chain [0:TABLE_DEPTH];
    flow_key_t        key_chain [0:TABLE_DEPTH];
    logic [IDX_W-1:0] idx_chain [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] used_vec;

    flow_ctl_t        last_ctl;
    logic [IDX_W-1:0] last_idx;
    logic [INDEX_W-1:0] idx_low;

    // every cycle moves each word one cell on, so a new word is always welcome
    assign busy = 1'b0;

    // word entering the chain
    assign ctl_chain[0] = '{valid: start && !busy, hit: 1'b0, ins: 1'b0};
    assign key_chain[0] = {protocol, source_address, destination_address,
                           source_port, destination_port};
    assign idx_chain[0] = '0;

    // the cell row; occupied cells always form a prefix, so the first free
    // cell a missing word meets is the next free slot of the table
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++)
    begin : g_cell
        ctl_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (gi)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctl   (ctl_chain[gi]),
            .in_key   (key_chain[gi]),
            .in_idx   (idx_chain[gi]),
            .out_ctl  (ctl_chain[gi+1]),
            .out_key  (key_chain[gi+1]),
            .out_idx  (idx_chain[gi+1]),
            .occupied (used_vec[gi])
        );
    end

    assign last_ctl = ctl_chain[TABLE_DEPTH];
    assign last_idx = idx_chain[TABLE_DEPTH];

    // low bits of the slot number onto the 8-bit index port
    if (IDX_W >= INDEX_W)
    begin : g_idx_trunc
        assign idx_low = last_idx[INDEX_W-1:0];
    end
    else
    begin : g_idx_ext
        assign idx_low = {{(INDEX_W-IDX_W){1'b0}}, last_idx};
    end

    // result decode straight off the last cell's registers
    assign done       = last_ctl.valid;
    assign found      = last_ctl.valid && last_ctl.hit;
    assign inserted   = last_ctl.valid && last_ctl.ins;
    // a word that left the chain with neither hit nor slot found no room
    assign table_full = last_ctl.valid && !last_ctl.hit && !last_ctl.ins;
    assign entry_index = (found || inserted) ? idx_low : '0;

`ifndef SYNTHESIS
    // occupied cells never leave a gap
    a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((used_vec >> 1) & ~used_vec) == '0)
        else $error("occupied cells not contiguous");

    // each result carries exactly one outcome
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot({found, inserted, table_full}))
        else $error("result outcome flags not one-hot");

    // a full report only when every cell holds a key
    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        table_full |-> (&used_vec))
        else $error("table full reported with a free cell");

    // no outcome flags outside a done cycle
    a_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!found && !inserted && !table_full))
        else $error("outcome flag without done");
`endif

endmodule

// ===== verif/connection_table_lookup_insert_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_table_lookup_insert_tb: self-checking bench for the flow table
// drives five-tuple key words through the command port and follows the table
// contents on the side, so every done word is checked for found, inserted,
// table_full and entry_index; the run fills the table and keeps going past
// the point where it is full
// ----------------------------------------------------------------------------
module connection_table_lookup_insert_tb;
    import ctl_pkg::*;

    // block configuration and run sizing
    localparam int unsigned TABLE_DEPTH  = 256;
    localparam int unsigned RANDOM_WORDS = 1935;
    // the watchdog limit covers the longest sender gap plus the chain length, with margin
    localparam int unsigned STALL_LIMIT  = 8 * (400 + TABLE_DEPTH);
    localparam int unsigned KEY_W        = $bits(flow_key_t);

    // one result word as the block reports it
    typedef struct packed {
        logic               found;
        logic               inserted;
        logic               table_full;
        logic [INDEX_W-1:0] entry_index;
    } lookup_result_t;

    // shadow of the flow table plus the words still owed by the block
    class flow_table_model;
        flow_key_t      stored_keys[TABLE_DEPTH];
        int unsigned    used_slots;
        lookup_result_t owed_results[$];
        int unsigned    mismatches;

        function new();
            used_slots  = 0;
            mismatches  = 0;
        endfunction

        // search the occupied slots, last match wins, insert on a miss, report full when no slot is left
        function void note_lookup(flow_key_t key);
            lookup_result_t res;
            bit             hit;
            int unsigned    hit_slot;
            hit      = 0;
            hit_slot = 0;
            for (int unsigned s = 0; s < used_slots; s++)
            begin
                if (stored_keys[s] == key)
                begin
                    hit      = 1;
                    hit_slot = s;
                end
            end
            res = '0;
            if (hit)
            begin
                res.found       = 1'b1;
                res.entry_index = hit_slot[INDEX_W-1:0];
            end
            else if (used_slots < TABLE_DEPTH)
            begin
                stored_keys[used_slots] = key;
                res.inserted    = 1'b1;
                res.entry_index = used_slots[INDEX_W-1:0];
                used_slots++;
            end
            else
            begin
                res.table_full = 1'b1;
            end
            owed_results.push_back(res);
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with none owed:", $realtime,
                             " found=%0b ins=%0b full=%0b idx=%0d",
                             got.found, got.inserted, got.table_full,
                             got.entry_index);
                return;
            end
            want = owed_results.pop_front();
            if (got.found !== want.found || got.inserted !== want.inserted ||
                got.table_full !== want.table_full ||
                got.entry_index !== want.entry_index)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp found=%0b ins=%0b full=%0b idx=%0d,",
                             $realtime, want.found, want.inserted, want.table_full,
                             want.entry_index,
                             " got found=%0b ins=%0b full=%0b idx=%0d",
                             got.found, got.inserted, got.table_full,
                             got.entry_index);
            end
        endfunction

        function int unsigned owed_count();
            return owed_results.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [PROTO_W-1:0] protocol;
    logic [ADDR_W-1:0]  source_address;
    logic [ADDR_W-1:0]  destination_address;
    logic [PORT_W-1:0]  source_port;
    logic [PORT_W-1:0]  destination_port;
    logic               done;
    logic               found;
    logic               inserted;
    logic               table_full;
    logic [INDEX_W-1:0] entry_index;

    flow_table_model    flow_book = new();
    flow_key_t          sent_keys[$];   // every key offered so far, for repeats
    int unsigned        quiet_cycles;

    connection_table_lookup_insert #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .protocol            (protocol),
        .source_address      (source_address),
        .destination_address (destination_address),
        .source_port         (source_port),
        .destination_port    (destination_port),
        .done                (done),
        .found               (found),
        .inserted            (inserted),
        .table_full          (table_full),
        .entry_index         (entry_index)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // present one key word and hold it until the block takes it;
    // start is left high so a back-to-back word needs no extra edge
    task automatic send_key(input flow_key_t key);
        start               <= 1'b1;
        protocol            <= key.protocol;
        source_address      <= key.source_address;
        destination_address <= key.destination_address;
        source_port         <= key.source_port;
        destination_port    <= key.destination_port;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        flow_book.note_lookup(key);
        sent_keys.push_back(key);
    endtask

    // idle the command side; junk on the key ports while start is low
    task automatic idle_cycles(input int unsigned n);
        if (n > 0)
        begin
            start               <= 1'b0;
            protocol            <= PROTO_W'($urandom);
            source_address      <= ADDR_W'($urandom);
            destination_address <= ADDR_W'($urandom);
            source_port         <= PORT_W'($urandom);
            destination_port    <= PORT_W'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // mostly short gaps, a few long enough to drain the whole chain
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(20, 4);
        else
            return $urandom_range(400, 50);
    endfunction

    function automatic flow_key_t random_key();
        flow_key_t k;
        k.protocol            = PROTO_W'($urandom);
        k.source_address      = ADDR_W'($urandom);
        k.destination_address = ADDR_W'($urandom);
        k.source_port         = PORT_W'($urandom);
        k.destination_port    = PORT_W'($urandom);
        return k;
    endfunction

    // repeats hit stored entries, one-bit neighbors stress every compare
    // bit, fresh keys fill the table and later run into the full case
    function automatic flow_key_t pick_key();
        flow_key_t   k;
        int unsigned r;
        r = $urandom_range(99);
        if (sent_keys.size() == 0 || r >= 80)
            return random_key();
        k = sent_keys[$urandom_range(sent_keys.size() - 1)];
        if (r >= 55)
            k = k ^ (flow_key_t'(1) << $urandom_range(KEY_W - 1));
        return k;
    endfunction

    // result side: the receiver cannot stall, so every done cycle is a word
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            flow_book.check_result('{found, inserted, table_full, entry_index});
    end

    // watchdog on cycles where neither side moves a word
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("connection_table_lookup_insert regression: fail");
            $finish;
        end
    end

    initial
    begin
        flow_key_t   zero_key;
        flow_key_t   ones_key;
        flow_key_t   stripe_a;
        flow_key_t   stripe_b;
        int unsigned burst_left;
        int unsigned gap;

        zero_key   = '0;
        ones_key   = '1;
        stripe_a   = {13{8'hAA}};
        stripe_b   = {13{8'h55}};
        burst_left = 0;

        quiet_cycles        = 0;
        rst_n               <= 1'b0;
        start               <= 1'b0;
        protocol            <= '0;
        source_address      <= '0;
        destination_address <= '0;
        source_port         <= '0;
        destination_port    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, exact repeats and keys one bit away
        // from a stored key in each field, mostly back to back
        send_key(zero_key);
        send_key(ones_key);
        send_key(zero_key);
        send_key(ones_key);
        send_key(zero_key ^ {8'h80, 96'h0});
        send_key(zero_key ^ {8'h00, 32'h1, 64'h0});
        send_key(zero_key ^ {8'h00, 32'h0, 32'h8000_0000, 32'h0});
        idle_cycles(3);
        send_key(zero_key ^ {72'h0, 16'h8000, 16'h0});
        send_key(zero_key ^ {88'h0, 16'h0001});
        send_key(ones_key ^ {8'h01, 96'h0});
        send_key(stripe_a);
        send_key(stripe_b);
        // let the chain drain, then hit entries again and insert one neighbor from an empty pipe
        idle_cycles(TABLE_DEPTH + 8);
        send_key(zero_key);
        send_key(stripe_a);
        send_key(ones_key ^ {8'h01, 96'h0});
        send_key(stripe_b ^ {88'h0, 16'h0001});

        // random: the table fills part way through, after that new keys
        // report full and stored ones are still found
        for (int unsigned n = 0; n < RANDOM_WORDS; n++)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
                gap = 0;
            end
            else
            begin
                gap = pick_gap();
                if ($urandom_range(99) < 4)
                    burst_left = $urandom_range(60, 20);
            end
            idle_cycles(gap);
            send_key(pick_key());
        end
        idle_cycles(1);

        // wait for every owed word, then watch for strays past the latency
        while (flow_book.owed_count() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        if (flow_book.mismatches == 0 && flow_book.owed_count() == 0)
            $display("connection_table_lookup_insert regression: pass");
        else
            $display("connection_table_lookup_insert regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ctl_pkg.sv
hw/rtl/ctl_cell.sv
hw/rtl/connection_table_lookup_insert.sv
verif/connection_table_lookup_insert_tb.sv
